// ----- hdl/led_matrix_frame_engine_defines.svh -----
// Assertion macros shared by the frame engine checker.
// Every macro expects signals named clk and rst in the enclosing scope.
`ifndef LED_MATRIX_FRAME_ENGINE_DEFINES_SVH
`define LED_MATRIX_FRAME_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lmfe_pkg.sv -----
// Types and constants for the LED matrix frame engine.
// No dependencies; the top level, queue, front end and back end import it.
package lmfe_pkg;

  localparam int ROWS = 8;

  localparam logic [3:0] ACT_LOAD_ROW   = 4'd0;
  localparam logic [3:0] ACT_REFRESH    = 4'd1;
  localparam logic [3:0] ACT_SET_LED    = 4'd2;
  localparam logic [3:0] ACT_SET_COLUMN = 4'd3;
  localparam logic [3:0] ACT_CLEAR      = 4'd4;
  localparam logic [3:0] ACT_FILL       = 4'd5;
  localparam logic [3:0] ACT_INVERT     = 4'd6;
  localparam logic [3:0] ACT_SHL        = 4'd7;
  localparam logic [3:0] ACT_SHR        = 4'd8;
  localparam logic [3:0] ACT_UP         = 4'd9;
  localparam logic [3:0] ACT_DOWN       = 4'd10;
  localparam logic [3:0] ACT_RAW_ROW    = 4'd11;
  localparam logic [3:0] ACT_INTENSITY  = 4'd12;
  localparam logic [3:0] ACT_SCANLIMIT  = 4'd13;
  localparam logic [3:0] ACT_SHUTDOWN   = 4'd14;

  localparam logic [3:0] ADDR_ROW_FIRST = 4'd1;
  localparam logic [3:0] ADDR_INTENSITY = 4'd10;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'd11;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'd12;

  localparam logic [2:0] LAST_ROW = 3'd7;
  localparam logic [7:0] ROW_ONES = 8'hFF;

  // Frame store update carried out by the back end.
  typedef enum logic [3:0] {
    UPD_NONE,
    UPD_LOAD,
    UPD_PIXEL,
    UPD_COLUMN,
    UPD_CLEAR,
    UPD_FILL,
    UPD_INVERT,
    UPD_SHL,
    UPD_SHR,
    UPD_UP,
    UPD_DOWN
  } upd_t;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] row_index;
    logic [2:0] column_index;
    logic       pixel_on;
    logic [7:0] data_byte;
    logic [3:0] shift_amount;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0] cmd_address;
    logic [7:0] cmd_data;
    logic       last_word;
  } cmd_word_t;

  // Classified command held in the queue between front and back end.
  typedef struct packed {
    logic       is_word;    // single display word, store untouched
    upd_t       upd;
    logic [2:0] row;
    logic [2:0] col;
    logic       pix;
    logic [7:0] data;
    logic [2:0] amount;
    logic       clear_all;  // shift of eight or more
    logic [3:0] word_addr;
    logic [7:0] word_data;
  } op_t;

endpackage

// ----- hdl/lmfe_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; no other dependencies.
interface lmfe_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/led_matrix_frame_engine.sv -----
// LED matrix frame engine, top level. A frame command first applies its update to the
// frame store, then sends eight row words at one per cycle while the sink does not
// stall, paced by the single output register. Display-control and raw row commands
// send a single word. Synchronous active-high rst clears the frame store to all zeros,
// empties the queue and drops any pending output word.
module led_matrix_frame_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  lmfe_stream_if.sink   cmd_in,
  lmfe_stream_if.source word_out
);
  import lmfe_pkg::*;

  // Classified commands, front end to queue and queue to back end.
  lmfe_stream_if #(.payload_t(op_t)) front_to_queue ();
  lmfe_stream_if #(.payload_t(op_t)) queue_to_back ();

  // Front end: decode the action code, fold the shift distance into a
  // clear flag and a 3-bit distance, and precompute single-word commands.
  // The unused action code is accepted and dropped here.
  lmfe_front u_front (
    .cmd_in (cmd_in),
    .op_out (front_to_queue)
  );

  // Queue: lets the input keep accepting while the back end is busy
  // streaming out the eight rows of an earlier frame command.
  lmfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_to_queue),
    .pop  (queue_to_back)
  );

  // Back end: apply the frame update to the store, then walk rows 1 to 8
  // through the output register; hold while the sink stalls.
  lmfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_in    (queue_to_back),
    .word_out (word_out)
  );
endmodule

// ----- hdl/lmfe_queue.sv -----
// Short FIFO of classified commands between front and back end.
// Depends on lmfe_pkg (op_t) and lmfe_stream_if.
module lmfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  lmfe_stream_if.sink   push,
  lmfe_stream_if.source pop
);
  import lmfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push.ready  = (count != CNT_W'(DEPTH));
  assign pop.valid   = (count != '0);
  assign pop.payload = entries[rd_ptr];
  assign do_push     = push.valid && push.ready;
  assign do_pop      = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push.payload;
        if (wr_ptr == PTR_W'(DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (do_pop) begin
        if (rd_ptr == PTR_W'(DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- hdl/lmfe_front.sv -----
// Front end: accepts command transactions and classifies them into queue entries.
// Depends on lmfe_pkg and lmfe_stream_if.
module lmfe_front (
  lmfe_stream_if.sink   cmd_in,
  lmfe_stream_if.source op_out
);
  import lmfe_pkg::*;

  cmd_item_t cmd;
  op_t       op;
  logic      known;

  assign cmd = cmd_in.payload;

  always_comb begin
    op           = '0;
    op.upd       = UPD_NONE;
    op.row       = cmd.row_index;
    op.col       = cmd.column_index;
    op.pix       = cmd.pixel_on;
    op.data      = cmd.data_byte;
    op.amount    = cmd.shift_amount[2:0];
    op.clear_all = cmd.shift_amount[3];
    op.word_data = cmd.data_byte;
    known        = 1'b1;

    unique case (cmd.action) inside
      ACT_RAW_ROW, ACT_INTENSITY, ACT_SCANLIMIT, ACT_SHUTDOWN: op.is_word = 1'b1;
      default:                                                 op.is_word = 1'b0;
    endcase

    unique case (cmd.action)
      ACT_LOAD_ROW:   op.upd = UPD_LOAD;
      ACT_REFRESH:    op.upd = UPD_NONE;
      ACT_SET_LED:    op.upd = UPD_PIXEL;
      ACT_SET_COLUMN: op.upd = UPD_COLUMN;
      ACT_CLEAR:      op.upd = UPD_CLEAR;
      ACT_FILL:       op.upd = UPD_FILL;
      ACT_INVERT:     op.upd = UPD_INVERT;
      ACT_SHL:        op.upd = UPD_SHL;
      ACT_SHR:        op.upd = UPD_SHR;
      ACT_UP:         op.upd = UPD_UP;
      ACT_DOWN:       op.upd = UPD_DOWN;
      ACT_RAW_ROW:    op.word_addr = {1'b0, cmd.row_index} + ADDR_ROW_FIRST;
      ACT_INTENSITY:  op.word_addr = ADDR_INTENSITY;
      ACT_SCANLIMIT:  op.word_addr = ADDR_SCANLIMIT;
      ACT_SHUTDOWN: begin
        op.word_addr = ADDR_SHUTDOWN;
        op.word_data = {7'b0, ~cmd.pixel_on};
      end
      default:        known = 1'b0;
    endcase
  end

  // Drop the unused code outright; everything else waits for queue space.
  assign op_out.valid   = cmd_in.valid && known;
  assign op_out.payload = op;
  assign cmd_in.ready   = op_out.ready || !known;
endmodule

// ----- hdl/lmfe_back.sv -----
// Back end: owns the 8x8 frame store, applies updates and sends display words.
// Depends on lmfe_pkg and lmfe_stream_if.
module lmfe_back (
  input  logic          clk,
  input  logic          rst,
  lmfe_stream_if.sink   op_in,
  lmfe_stream_if.source word_out
);
  import lmfe_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t          state;
  logic [7:0]      rows [ROWS];
  logic [7:0]      rows_next [ROWS];
  logic [2:0]      row_ctr;
  logic            out_valid;
  cmd_word_t       out_word;
  op_t             op;
  logic            load_slot;
  logic            take_op;
  logic [8*ROWS-1:0] flat;
  logic [8*ROWS-1:0] flat_moved;
  logic [5:0]      move_bits;

  assign op               = op_in.payload;
  assign load_slot        = !out_valid || word_out.ready;
  assign op_in.ready      = (state == ST_IDLE) && load_slot;
  assign take_op          = op_in.valid && op_in.ready;
  assign word_out.valid   = out_valid;
  assign word_out.payload = out_word;

  // Row moves: up pulls higher rows down, down pushes lower rows up.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      flat[r*8 +: 8] = rows[r];
    end
    move_bits  = {op.amount, 3'b000};
    flat_moved = (op.upd == UPD_UP) ? (flat >> move_bits) : (flat << move_bits);
  end

  always_comb begin
    rows_next = rows;
    unique case (op.upd)
      UPD_LOAD:  rows_next[op.row] = op.data;
      UPD_PIXEL: rows_next[op.row][op.col] = op.pix;
      UPD_COLUMN: begin
        for (int r = 0; r < ROWS; r++) begin
          rows_next[r][op.col] = op.data[r];
        end
      end
      UPD_CLEAR: begin
        for (int r = 0; r < ROWS; r++) begin
          rows_next[r] = '0;
        end
      end
      UPD_FILL: begin
        for (int r = 0; r < ROWS; r++) begin
          rows_next[r] = ROW_ONES;
        end
      end
      UPD_INVERT: begin
        for (int r = 0; r < ROWS; r++) begin
          rows_next[r] = rows[r] ^ ROW_ONES;
        end
      end
      UPD_SHL: begin
        for (int r = 0; r < ROWS; r++) begin
          rows_next[r] = op.clear_all ? '0 : (rows[r] << op.amount);
        end
      end
      UPD_SHR: begin
        for (int r = 0; r < ROWS; r++) begin
          rows_next[r] = op.clear_all ? '0 : (rows[r] >> op.amount);
        end
      end
      UPD_UP, UPD_DOWN: begin
        for (int r = 0; r < ROWS; r++) begin
          rows_next[r] = op.clear_all ? '0 : flat_moved[r*8 +: 8];
        end
      end
      default: rows_next = rows;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      row_ctr   <= '0;
      for (int r = 0; r < ROWS; r++) begin
        rows[r] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take_op && op.is_word) begin
            out_valid <= 1'b1;
            out_word  <= '{cmd_address: op.word_addr, cmd_data: op.word_data,
                           last_word: 1'b1};
          end else if (word_out.ready) begin
            out_valid <= 1'b0;
          end
          if (take_op && !op.is_word) begin
            rows    <= rows_next;
            row_ctr <= '0;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load_slot) begin
            out_valid <= 1'b1;
            out_word  <= '{cmd_address: {1'b0, row_ctr} + ADDR_ROW_FIRST,
                           cmd_data: rows[row_ctr],
                           last_word: (row_ctr == LAST_ROW)};
            row_ctr   <= row_ctr + 1'b1;
            if (row_ctr == LAST_ROW) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/lmfe_checker.sv -----
// Port-level checker for the frame engine, bound to the top level.
// Depends on led_matrix_frame_engine_defines.svh.
`include "led_matrix_frame_engine_defines.svh"

module lmfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_address,
  input logic [7:0] out_data,
  input logic       out_last
);
  // Hold a stalled word.
  `LMFE_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_address) && $stable(out_data) && $stable(out_last), "stalled word changed")

  // Non-final words only come from rows 1 to 7 of a frame burst.
  `LMFE_ASSERT_NOW(a_mid_burst_row, out_valid && !out_last, out_address >= 4'd1 && out_address <= 4'd7, "non-final word outside rows 1 to 7")

  // Row 8 and every control register word close their transaction.
  `LMFE_ASSERT_NOW(a_final_word, out_valid && out_address >= 4'd8, out_last, "row 8 or control word not marked last")

  // Only row and control register addresses appear.
  `LMFE_ASSERT_NOW(a_addr_range, out_valid, out_address != 4'd0 && out_address != 4'd9 && out_address <= 4'd12, "illegal display address")

  // Shutdown data is a single flag bit.
  `LMFE_ASSERT_NOW(a_shutdown_data, out_valid && out_address == 4'd12, out_data[7:1] == 7'd0, "shutdown data not 0 or 1")
endmodule

bind led_matrix_frame_engine lmfe_checker u_lmfe_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (word_out.valid),
  .out_ready   (word_out.ready),
  .out_address (word_out.payload.cmd_address),
  .out_data    (word_out.payload.cmd_data),
  .out_last    (word_out.payload.last_word)
);
